>>> src/base64_stream_codec_macros.svh
// assertion macros for the base64 stream codec
`ifndef BASE64_STREAM_CODEC_MACROS_SVH
`define BASE64_STREAM_CODEC_MACROS_SVH
`ifndef SYNTHESIS
`define B64_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64 assertion failed");
`define B64_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64 assertion failed");
`else
`define B64_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define B64_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/b64_pkg.sv
// shared types, codes and alphabet functions of the base64 stream codec
package b64_pkg;

  // one result word
  typedef struct packed {
    logic [7:0] value;
    logic       valid;
    logic       eos;
    logic [1:0] status;
  } b64_res_t;

  // load request from the codec logic to the result buffer
  typedef struct packed {
    logic       load;
    logic [2:0] cnt;
  } b64_ld_t;

  localparam int unsigned N_RES = 4;

  // cfg address width, register select sits on bit 2
  localparam int unsigned CFG_AW = 3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // register select, taken from paddr bit 2
  localparam logic REG_MODE = 1'b0;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // 6-bit value to alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // character to 6-bit value, bit 6 flags a character outside the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else begin
      r = 7'h40;
    end
    return r;
  endfunction

endpackage

>>> src/b64_if.sv
// stream channel interfaces of the base64 stream codec

// input channel: one byte or character per word
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_item;

  modport source (output valid, output in_byte, output last_item, input ready);
  modport sink (input valid, input in_byte, input last_item, output ready);
endinterface

// result channel: one character, byte or status per word
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       out_valid;
  logic       end_of_stream;
  logic [1:0] status;

  modport source (output valid, output out_value, output out_valid,
                  output end_of_stream, output status, input ready);
  modport sink (input valid, input out_value, input out_valid,
                input end_of_stream, input status, output ready);
endinterface

>>> src/b64_outbuf.sv
// result buffer: holds up to four result words and sends them one per cycle while the receiver is ready
`include "base64_stream_codec_macros.svh"

module b64_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  b64_pkg::b64_ld_t  ld,
  input  b64_pkg::b64_res_t ld_items [b64_pkg::N_RES],
  output logic              can_load,
  output logic              head_valid,
  output b64_pkg::b64_res_t head,
  input  logic              head_ready
);

  b64_pkg::b64_res_t items_r [b64_pkg::N_RES];
  logic [2:0]        rem_r;
  logic [2:0]        rem_nxt;
  logic              pop;

  // handshake side
  assign head_valid = (rem_r != 3'd0);
  assign head       = items_r[0];
  assign pop        = head_valid && head_ready;
  assign can_load   = (rem_r == 3'd0) || (rem_r == 3'd1 && head_ready);

  // fill count
  always_comb begin
    if (ld.load) begin
      rem_nxt = ld.cnt;
    end else if (pop) begin
      rem_nxt = rem_r - 3'd1;
    end else begin
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // word storage, shifts toward the head on each send
  always_ff @(posedge clk) begin
    if (ld.load) begin
      for (int i = 0; i < b64_pkg::N_RES; i++) begin
        items_r[i] <= ld_items[i];
      end
    end else if (pop) begin
      for (int i = 0; i < b64_pkg::N_RES - 1; i++) begin
        items_r[i] <= items_r[i + 1];
      end
    end
  end

  `B64_ASSERT_IMP(a_load_when_free, clk, rst_n, ld.load && rem_r != 3'd0, rem_r == 3'd1 && pop)
  `B64_ASSERT_IMP(a_rem_bound, clk, rst_n, 1'b1, rem_r <= 3'd4)
  `B64_ASSERT_NXT(a_rem_drain, clk, rst_n, pop && !ld.load, rem_r == $past(rem_r) - 3'd1)

endmodule

>>> src/base64_stream_codec.sv
// Base64 stream codec (standard alphabet), encode or decode set by the mode register
//
// in_ch takes one byte (encode) or one character (decode) per word, with
// last_item on the final word of a stream. out_ch gives characters, decoded
// bytes and status-only words (out_valid low). A word is moved when valid and
// ready are both high.
// Each accepted input word is worked out in the same cycle and its results are
// loaded into a four-entry result buffer; the first result shows on out_ch in
// the next cycle and the rest follow one per cycle while the receiver is ready.
// Encoding gives one or two characters per byte (up to four on the last byte,
// with padding); decoding gives at most one byte plus one end word. The next
// input word is taken in the cycle the last buffered result leaves, so
// throughput is one word per cycle when each word causes at most one result and
// the receiver is ready, else the single output port gives one result per cycle.
// When the receiver stalls, the buffer holds and in_ch.ready drops until the
// last buffered result is taken. Reset (rst_n low, synchronous) sets mode to
// encode and clears the stream state and the buffer. Writing the mode register
// at byte address 0 through the cfg port also starts a new stream.
`include "base64_stream_codec_macros.svh"

module base64_stream_codec (
  input  logic                        clk,
  input  logic                        rst_n,
  b64_in_if.sink                      in_ch,
  b64_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [b64_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic              mode_r;
  logic              enc_mode;
  logic [11:0]       held_bits_r;
  logic [11:0]       held_bits_nxt;
  logic [2:0]        held_count_r;
  logic [2:0]        held_count_nxt;
  logic [1:0]        char_phase_r;
  logic [1:0]        char_phase_nxt;
  logic              pad_seen_r;
  logic              pad_seen_nxt;
  logic [1:0]        error_code_r;
  logic [1:0]        error_code_nxt;
  b64_pkg::b64_res_t res [b64_pkg::N_RES];
  logic [2:0]        n_res;
  logic              in_acc;
  logic              can_load;
  logic              cfg_wr;
  logic              mode_sel;
  b64_pkg::b64_ld_t  ld;
  b64_pkg::b64_res_t head;

  // config port
  assign cfg_pready = 1'b1;
  assign mode_sel   = (cfg_paddr[2] == b64_pkg::REG_MODE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && mode_sel;
  assign cfg_prdata = mode_sel ? {31'd0, mode_r} : 32'd0;

  assign in_ch.ready = can_load;
  assign in_acc      = in_ch.valid && can_load;
  assign enc_mode    = (mode_r == b64_pkg::MODE_ENC);

  // per-word codec logic
  always_comb begin
    logic [11:0] hbx;
    logic [6:0]  sx;
    logic [5:0]  tail;
    logic [2:0]  lc;
    for (int i = 0; i < b64_pkg::N_RES; i++) begin
      res[i] = '0;
    end
    n_res          = 3'd0;
    held_bits_nxt  = held_bits_r;
    held_count_nxt = held_count_r;
    char_phase_nxt = char_phase_r;
    pad_seen_nxt   = pad_seen_r;
    error_code_nxt = error_code_r;
    hbx            = '0;
    sx             = '0;
    tail           = '0;
    lc             = '0;
    if (enc_mode) begin
      // encode: at most four bits carried over from the previous byte
      hbx = {held_bits_r[3:0], in_ch.in_byte};
      case (held_count_r)
        3'd2: begin
          res[n_res[1:0]] = '{b64_pkg::sextet_to_char(hbx[9:4]), 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          lc    = 3'd4;
          tail  = {hbx[3:0], 2'b00};
        end
        3'd4: begin
          res[n_res[1:0]] = '{b64_pkg::sextet_to_char(hbx[11:6]), 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          res[n_res[1:0]] = '{b64_pkg::sextet_to_char(hbx[5:0]), 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          lc    = 3'd0;
        end
        default: begin
          res[n_res[1:0]] = '{b64_pkg::sextet_to_char(hbx[7:2]), 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          lc    = 3'd2;
          tail  = {hbx[1:0], 4'b0000};
        end
      endcase
      held_bits_nxt  = hbx;
      held_count_nxt = lc;
      // flush the partial group and pad
      if (in_ch.last_item) begin
        if (lc != 3'd0) begin
          res[n_res[1:0]] = '{b64_pkg::sextet_to_char(tail), 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          res[n_res[1:0]] = '{b64_pkg::PAD_CHAR, 1'b1, 1'b0, b64_pkg::ST_OK};
          n_res = n_res + 3'd1;
          if (lc == 3'd2) begin
            res[n_res[1:0]] = '{b64_pkg::PAD_CHAR, 1'b1, 1'b0, b64_pkg::ST_OK};
            n_res = n_res + 3'd1;
          end
        end
        res[2'(n_res - 3'd1)].eos = 1'b1;
      end
    end else begin
      // decode: at most six bits carried over from previous characters
      char_phase_nxt = char_phase_r + 2'd1;
      if (!pad_seen_r && error_code_r == b64_pkg::ST_OK) begin
        if (in_ch.in_byte == b64_pkg::PAD_CHAR) begin
          pad_seen_nxt = 1'b1;
        end else begin
          sx = b64_pkg::char_to_sextet(in_ch.in_byte);
          if (sx[6]) begin
            error_code_nxt = b64_pkg::ST_BAD_CHAR;
            if (!in_ch.last_item) begin
              res[n_res[1:0]] = '{8'd0, 1'b0, 1'b0, b64_pkg::ST_BAD_CHAR};
              n_res = n_res + 3'd1;
            end
          end else begin
            hbx = {held_bits_r[5:0], sx[5:0]};
            held_bits_nxt = hbx;
            case (held_count_r)
              3'd2: begin
                res[n_res[1:0]] = '{hbx[7:0], 1'b1, 1'b0, b64_pkg::ST_OK};
                n_res = n_res + 3'd1;
                held_count_nxt = 3'd0;
              end
              3'd4: begin
                res[n_res[1:0]] = '{hbx[9:2], 1'b1, 1'b0, b64_pkg::ST_OK};
                n_res = n_res + 3'd1;
                held_count_nxt = 3'd2;
              end
              3'd6: begin
                res[n_res[1:0]] = '{hbx[11:4], 1'b1, 1'b0, b64_pkg::ST_OK};
                n_res = n_res + 3'd1;
                held_count_nxt = 3'd4;
              end
              default: begin
                held_count_nxt = 3'd6;
              end
            endcase
          end
        end
      end
      // end word with the stream status
      if (in_ch.last_item) begin
        res[n_res[1:0]] = '{8'd0, 1'b0, 1'b1,
                            (char_phase_nxt != 2'd0) ? b64_pkg::ST_BAD_LEN : error_code_nxt};
        n_res = n_res + 3'd1;
      end
    end
    // a new stream starts after the last word
    if (in_ch.last_item) begin
      held_bits_nxt  = '0;
      held_count_nxt = '0;
      char_phase_nxt = '0;
      pad_seen_nxt   = 1'b0;
      error_code_nxt = b64_pkg::ST_OK;
    end
  end

  // mode and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= b64_pkg::MODE_ENC;
      held_bits_r  <= '0;
      held_count_r <= '0;
      char_phase_r <= '0;
      pad_seen_r   <= 1'b0;
      error_code_r <= b64_pkg::ST_OK;
    end else if (cfg_wr) begin
      mode_r       <= cfg_pwdata[0];
      held_bits_r  <= '0;
      held_count_r <= '0;
      char_phase_r <= '0;
      pad_seen_r   <= 1'b0;
      error_code_r <= b64_pkg::ST_OK;
    end else if (in_acc) begin
      held_bits_r  <= held_bits_nxt;
      held_count_r <= held_count_nxt;
      char_phase_r <= char_phase_nxt;
      pad_seen_r   <= pad_seen_nxt;
      error_code_r <= error_code_nxt;
    end
  end

  // result buffer
  assign ld.load = in_acc;
  assign ld.cnt  = n_res;

  b64_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .ld_items   (res),
    .can_load   (can_load),
    .head_valid (out_ch.valid),
    .head       (head),
    .head_ready (out_ch.ready)
  );

  assign out_ch.out_value     = head.value;
  assign out_ch.out_valid     = head.valid;
  assign out_ch.end_of_stream = head.eos;
  assign out_ch.status        = head.status;

  `B64_ASSERT_IMP(a_enc_count, clk, rst_n, enc_mode, held_count_r <= 3'd4 && !held_count_r[0])
  `B64_ASSERT_IMP(a_dec_count, clk, rst_n, !enc_mode, !held_count_r[0])
  `B64_ASSERT_IMP(a_enc_status, clk, rst_n, out_ch.valid && enc_mode, out_ch.status == 2'd0)
  `B64_ASSERT_NXT(a_last_clears, clk, rst_n, in_acc && in_ch.last_item, char_phase_r == 2'd0)

endmodule

>>> tb/sv/base64_stream_codec_checker.sv
// result checker for the base64 stream codec: predicts every word and compares it
`timescale 1ns / 1ps

module base64_stream_codec_checker (
  input  logic       clk,
  input  logic       rst_n,
  b64_in_if          in_mon,
  b64_out_if         out_mon,
  input  logic       cfg_psel,
  input  logic       cfg_penable,
  input  logic       cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic       cfg_pready,
  output int         fail_count,
  output int         words_pending
);

  // predicted codec state
  logic        codec_mode;
  logic [15:0] bit_store;
  logic [3:0]  bit_count;
  logic [1:0]  char_count;
  logic        pad_taken;
  logic [1:0]  sticky_status;

  b64_pkg::b64_res_t expected_words[$];
  int                mismatches;

  // sextet to alphabet character
  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    logic [7:0] ch;
    if (idx == 6'd63) begin
      ch = "/";
    end else if (idx == 6'd62) begin
      ch = "+";
    end else if (idx >= 6'd52) begin
      ch = "0" + 8'(idx - 6'd52);
    end else if (idx >= 6'd26) begin
      ch = "a" + 8'(idx - 6'd26);
    end else begin
      ch = "A" + 8'(idx);
    end
    return ch;
  endfunction

  // alphabet character to sextet, msb set when the character is not in the alphabet
  function automatic logic [6:0] alpha_index(input logic [7:0] ch);
    logic [6:0] idx;
    idx = 7'h40;
    for (int i = 0; i < 64; i++) begin
      if (alpha_char(6'(i)) == ch) idx = 7'(i);
    end
    return idx;
  endfunction

  task automatic add_word(input logic [7:0] value, input logic valid, input logic eos,
                          input logic [1:0] status);
    b64_pkg::b64_res_t w;
    w.value  = value;
    w.valid  = valid;
    w.eos    = eos;
    w.status = status;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic clear_stream();
    bit_store     = '0;
    bit_count     = '0;
    char_count    = '0;
    pad_taken     = 1'b0;
    sticky_status = b64_pkg::ST_OK;
  endtask

  // expected words for one accepted input word
  task automatic predict_codec_words(input logic [7:0] data, input logic last);
    logic [15:0] shifted;
    logic [6:0]  sextet;
    int          pads;
    int          first_new;
    first_new = expected_words.size();
    pads = 0;
    if (codec_mode == b64_pkg::MODE_ENC) begin
      bit_store = {bit_store[7:0], data};
      bit_count = bit_count + 4'd8;
      while (bit_count >= 4'd6) begin
        shifted = bit_store >> (bit_count - 4'd6);
        add_word(alpha_char(shifted[5:0]), 1'b1, 1'b0, b64_pkg::ST_OK);
        bit_count = bit_count - 4'd6;
      end
      // flush the partial group, zero filled, then padding
      if (last && bit_count != 4'd0) begin
        shifted = bit_store << (4'd6 - bit_count);
        add_word(alpha_char(shifted[5:0]), 1'b1, 1'b0, b64_pkg::ST_OK);
        pads = (bit_count == 4'd2) ? 2 : 1;
      end
      for (int p = 0; p < pads; p++) add_word(b64_pkg::PAD_CHAR, 1'b1, 1'b0, b64_pkg::ST_OK);
      if (last) begin
        expected_words[expected_words.size() - 1].eos = 1'b1;
        clear_stream();
      end
    end else begin
      char_count = char_count + 2'd1;
      if (!pad_taken && sticky_status == b64_pkg::ST_OK) begin
        if (data == b64_pkg::PAD_CHAR) begin
          pad_taken = 1'b1;
        end else begin
          sextet = alpha_index(data);
          if (sextet[6]) begin
            sticky_status = b64_pkg::ST_BAD_CHAR;
            if (!last) add_word(8'h00, 1'b0, 1'b0, b64_pkg::ST_BAD_CHAR);
          end else begin
            bit_store = {bit_store[9:0], sextet[5:0]};
            bit_count = bit_count + 4'd6;
            if (bit_count >= 4'd8) begin
              shifted = bit_store >> (bit_count - 4'd8);
              add_word(shifted[7:0], 1'b1, 1'b0, b64_pkg::ST_OK);
              bit_count = bit_count - 4'd8;
            end
          end
        end
      end
      // end word, length error wins over a bad character
      if (last) begin
        add_word(8'h00, 1'b0, 1'b1,
                 (char_count != 2'd0) ? b64_pkg::ST_BAD_LEN : sticky_status);
        clear_stream();
      end
    end
    if (first_new > expected_words.size()) mismatches++;
  endtask

  always @(posedge clk) begin
    b64_pkg::b64_res_t got;
    b64_pkg::b64_res_t want;
    if (!rst_n) begin
      codec_mode = b64_pkg::MODE_ENC;
      clear_stream();
      expected_words.delete();
    end else begin
      // result word against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.value  = out_mon.out_value;
        got.valid  = out_mon.out_valid;
        got.eos    = out_mon.end_of_stream;
        got.status = out_mon.status;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word value %02h valid %0d eos %0d status %0d",
                   $realtime, got.value, got.valid, got.eos, got.status);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: word mismatch expected value %02h valid %0d eos %0d status %0d,",
                     $realtime, want.value, want.valid, want.eos, want.status,
                     " actual value %02h valid %0d eos %0d status %0d",
                     got.value, got.valid, got.eos, got.status);
            mismatches++;
          end
        end
      end
      // mode register write restarts the stream, other addresses are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == b64_pkg::REG_MODE) begin
          codec_mode = cfg_pwdata[0];
          clear_stream();
        end
      end
      if (in_mon.valid && in_mon.ready) predict_codec_words(in_mon.in_byte, in_mon.last_item);
    end
    fail_count    <= mismatches;
    words_pending <= expected_words.size();
  end

  initial begin
    mismatches    = 0;
    fail_count    = 0;
    words_pending = 0;
  end

endmodule

>>> tb/sv/base64_stream_codec_tb.sv
// top of the base64 stream codec testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module base64_stream_codec_tb;

  localparam logic [2:0] MODE_ADDR  = {b64_pkg::REG_MODE, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~b64_pkg::REG_MODE, 2'b00};
  localparam int         QUIET_LIMIT = 2000;
  localparam int         RANDOM_ITEMS = 270;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        no_idle;
  int          fail_count;
  int          words_pending;
  int          quiet_cycles;

  b64_in_if  in_ch ();
  b64_out_if out_ch ();

  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_codec uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  base64_stream_codec_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    out_ch.ready = no_idle || ($urandom_range(0, 99) >= 27);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("base64_stream_codec_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input word, called and returning at a falling edge
  task automatic send_word(input logic [7:0] data, input logic last);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.in_byte   = data;
    in_ch.last_item = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string text, input logic ends);
    for (int i = 0; i < text.len(); i++) send_word(text[i], ends && (i == text.len() - 1));
  endtask

  // wait for every expected word, then let the block settle
  task automatic settle_block();
    in_ch.valid = 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    settle_block();
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin
    int       items_sent;
    int       len;
    int       pads;
    int       pick;
    logic     ends;
    logic     cur_mode;
    logic [7:0] ch;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = 8'h00;
    in_ch.last_item = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    no_idle         = 1'b0;
    quiet_cycles    = 0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // encode from reset: single byte with two pads, FF FE pair with one pad, full group
    send_word(8'h00, 1'b1);
    write_reg(SPARE_ADDR, 32'hFFFF_FFFF);
    send_word(8'hFF, 1'b0);
    send_word(8'hFE, 1'b1);
    send_word(8'hFB, 1'b0);
    send_word(8'hEF, 1'b0);
    send_word(8'hBE, 1'b1);
    // stream cut short by a mode write
    send_word(8'h4D, 1'b0);
    send_word(8'h61, 1'b0);
    write_reg(MODE_ADDR, {31'h7FFF_FFFF, b64_pkg::MODE_ENC});
    send_word(8'h6E, 1'b1);

    // decode: full group, padding, bad character mid stream, data after padding
    write_reg(MODE_ADDR, {31'h0, b64_pkg::MODE_DEC});
    send_text("TWFu", 1'b1);
    send_text("TQ==", 1'b1);
    send_text("T!Q/", 1'b1);
    send_text("TQ=", 1'b0);
    send_word(8'hFF, 1'b1);
    // bad last character with a length error
    send_word("+", 1'b0);
    send_word(8'h00, 1'b1);

    // random streams
    cur_mode   = b64_pkg::MODE_DEC;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (items_sent >= 100 && items_sent < 160);
      if ($urandom_range(0, 99) < 35) begin
        cur_mode = 1'($urandom_range(0, 1));
        write_reg(MODE_ADDR, ($urandom() & 32'hFFFF_FFFE) | {31'h0, cur_mode});
      end
      ends = ($urandom_range(0, 9) != 0);
      if (cur_mode == b64_pkg::MODE_ENC) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_word(8'($urandom_range(0, 255)), ends && i == len - 1);
      end else if ($urandom_range(0, 99) < 80) begin
        // well-formed groups with optional padding at the end
        len  = 4 * (($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3));
        pads = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
          ch = (i >= len - pads) ? b64_pkg::PAD_CHAR : b64_chars[$urandom_range(0, 63)];
          send_word(ch, ends && i == len - 1);
        end
      end else begin
        // broken streams: pads, bad characters and odd lengths
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) ch = b64_chars[$urandom_range(0, 63)];
          else if (pick < 70) ch = b64_pkg::PAD_CHAR;
          else ch = 8'($urandom_range(0, 255));
          send_word(ch, ends && i == len - 1);
        end
      end
      items_sent += len;
    end
    no_idle = 1'b0;

    settle_block();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("base64_stream_codec_tb: clean");
    end else begin
      $display("base64_stream_codec_tb: errors");
    end
    $finish;
  end

endmodule
